@@ rtl/core/sfda_pkg.sv @@
// ----------------------------------------------------------------------------
// sfda_pkg: shared types and constants
// ASCII codes, conversion widths and controller states for the fixed-point
// decimal formatter.
// ----------------------------------------------------------------------------
package sfda_pkg;

  localparam int unsigned InWidth   = 32;
  localparam int unsigned CharWidth = 7;
  localparam int unsigned MagWidth  = 14;  // holds 9999
  localparam int unsigned NumDigits = 4;
  localparam int unsigned BcdWidth  = 4 * NumDigits;
  localparam int unsigned CntWidth  = 4;

  localparam logic [InWidth-1:0] LimitMag = InWidth'(9999);

  localparam logic [CharWidth-1:0] ChSpace = 7'd32;
  localparam logic [CharWidth-1:0] ChStar  = 7'd42;
  localparam logic [CharWidth-1:0] ChMinus = 7'd45;
  localparam logic [CharWidth-1:0] ChPoint = 7'd46;
  localparam logic [2:0]           DigitHi = 3'b011;  // ASCII '0' is 0x30

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_DONE
  } state_e;

endpackage

@@ rtl/core/signed_fixed_decimal_ascii.sv @@
// ----------------------------------------------------------------------------
// signed_fixed_decimal_ascii: hundredths to "sDD.DD" ASCII formatter
// The bit-serial shift-and-add-3 loop over the 14-bit magnitude runs 14
// conversion steps, then 1 format step loads the output register; a new
// beat is taken only in idle, after the previous result has been loaded.
// A stalled output holds the converter in its done state.
// Reset (rst_ni low, async) returns the controller to idle and drops out_valid_o.
// ----------------------------------------------------------------------------
module signed_fixed_decimal_ascii
  import sfda_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input channel
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic signed [31:0]   value_i,
  // output channel
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [6:0]           char_0_o,
  output logic [6:0]           char_1_o,
  output logic [6:0]           char_2_o,
  output logic [6:0]           char_3_o,
  output logic [6:0]           char_4_o,
  output logic [6:0]           char_5_o,
  output logic                 out_of_range_o
);

  // Controller
  state_e state_q, state_d;
  logic [CntWidth-1:0] cnt_q, cnt_d;

  // Datapath: binary magnitude shifts out MSB first into the BCD register
  logic [MagWidth-1:0] bin_q, bin_d;
  logic [BcdWidth-1:0] bcd_q, bcd_d;
  logic                neg_q, neg_d;
  logic                oor_q, oor_d;

  // Output register
  logic                 out_valid_q, out_valid_d;
  logic [CharWidth-1:0] ch0_q, ch1_q, ch2_q, ch4_q, ch5_q;
  logic [CharWidth-1:0] ch0_d, ch1_d, ch2_d, ch4_d, ch5_d;
  logic                 oor_out_q;

  logic                 in_beat;
  logic                 out_free;
  logic                 load_out;
  logic                 last_step;
  logic [InWidth-1:0]   mag_full;
  logic [BcdWidth-1:0]  bcd_adj;

  assign in_beat   = in_valid_i && in_ready_o;
  assign out_free  = !out_valid_q || out_ready_i;
  assign last_step = (cnt_q == CntWidth'(MagWidth - 1));

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_CONV;
      ST_CONV: if (last_step)  state_d = ST_DONE;
      ST_DONE: if (out_free)   state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Controls
  always_comb begin
    in_ready_o = 1'b0;
    load_out   = 1'b0;
    unique case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_CONV: ;
      ST_DONE: load_out   = out_free;
      default: ;
    endcase
  end

  // Magnitude and range check happen once, at the input beat
  assign mag_full = value_i[InWidth-1] ? (~value_i + InWidth'(1)) : value_i;

  // Add 3 to every BCD digit at 5 or above, ahead of the shift
  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? (bcd_q[4*i +: 4] + 4'd3)
                                                     : bcd_q[4*i +: 4];
    end
  end

  always_comb begin
    bin_d = bin_q;
    bcd_d = bcd_q;
    neg_d = neg_q;
    oor_d = oor_q;
    cnt_d = cnt_q;
    if (in_beat) begin
      bin_d = mag_full[MagWidth-1:0];
      bcd_d = '0;
      neg_d = value_i[InWidth-1];
      // above 9999, or below -9999 (the most negative value negates to itself)
      oor_d = value_i[InWidth-1] ? (mag_full[InWidth-1] || (mag_full > LimitMag))
                                 : (mag_full > LimitMag);
      cnt_d = '0;
    end else if (state_q == ST_CONV) begin
      bcd_d = {bcd_adj[BcdWidth-2:0], bin_q[MagWidth-1]};
      bin_d = {bin_q[MagWidth-2:0], 1'b0};
      cnt_d = cnt_q + CntWidth'(1);
    end
  end

  // Character formatting from the finished BCD digits
  always_comb begin
    logic [3:0] d3;
    d3 = bcd_q[15:12];
    if (oor_q) begin
      ch0_d = neg_q ? ChMinus : ChSpace;
      ch1_d = ChStar;
      ch2_d = ChStar;
      ch4_d = ChStar;
      ch5_d = ChStar;
    end else begin
      // sign moves to the front once the tens position holds a digit
      ch0_d = (neg_q && (d3 != 4'd0)) ? ChMinus : ChSpace;
      ch1_d = (d3 != 4'd0) ? {DigitHi, d3} : (neg_q ? ChMinus : ChSpace);
      ch2_d = {DigitHi, bcd_q[11:8]};
      ch4_d = {DigitHi, bcd_q[7:4]};
      ch5_d = {DigitHi, bcd_q[3:0]};
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
    neg_q <= neg_d;
    oor_q <= oor_d;
    if (load_out) begin
      ch0_q     <= ch0_d;
      ch1_q     <= ch1_d;
      ch2_q     <= ch2_d;
      ch4_q     <= ch4_d;
      ch5_q     <= ch5_d;
      oor_out_q <= oor_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign char_0_o       = ch0_q;
  assign char_1_o       = ch1_q;
  assign char_2_o       = ch2_q;
  assign char_3_o       = ChPoint;
  assign char_4_o       = ch4_q;
  assign char_5_o       = ch5_q;
  assign out_of_range_o = oor_out_q;

endmodule

@@ test/tb_signed_fixed_decimal_ascii.sv @@
// ----------------------------------------------------------------------------
// tb_signed_fixed_decimal_ascii: self-checking bench for the hundredths
// formatter
// Drives signed hundredths values through the valid/ready input channel and
// checks every "sDD.DD" beat on the output channel against a built-in
// formatter model. The sender runs in random bursts and the receiver stalls
// on a changing pattern of its own.
// ----------------------------------------------------------------------------
module tb_signed_fixed_decimal_ascii
  import sfda_pkg::*;
();

  localparam int unsigned MaxCycles  = 400000;  // far above the slowest legal run
  localparam int unsigned NumRandom  = 530;
  localparam int unsigned DrainWait  = 48;      // about three conversion times

  // One formatted display beat.
  typedef struct packed {
    logic [CharWidth-1:0] c0;
    logic [CharWidth-1:0] c1;
    logic [CharWidth-1:0] c2;
    logic [CharWidth-1:0] c3;
    logic [CharWidth-1:0] c4;
    logic [CharWidth-1:0] c5;
    logic                 oor;
  } disp_t;

  // --------------------------------------------------------------------------
  // Scoreboard: formats each accepted value and matches output beats in order
  // --------------------------------------------------------------------------
  class fmt_scoreboard;
    disp_t       pending[$];
    int unsigned errors;
    int unsigned values_seen;
    int unsigned beats_seen;
    int unsigned n_negative;
    int unsigned n_overflow;

    function new();
      errors      = 0;
      values_seen = 0;
      beats_seen  = 0;
      n_negative  = 0;
      n_overflow  = 0;
    endfunction

    function logic [CharWidth-1:0] digit_char(input int unsigned d);
      return {DigitHi, 4'(d)};
    endfunction

    // Hundredths value to "sDD.DD"; sign hugs the digits below 10.00.
    function disp_t format_hundredths(input logic signed [31:0] v);
      disp_t       d;
      int unsigned mag;
      d.c3 = ChPoint;
      if (v > 9999 || v < -9999) begin
        d.c0  = v[31] ? ChMinus : ChSpace;
        d.c1  = ChStar;
        d.c2  = ChStar;
        d.c4  = ChStar;
        d.c5  = ChStar;
        d.oor = 1'b1;
      end else begin
        mag   = v[31] ? int'(-v) : int'(v);
        d.c0  = ChSpace;
        d.c1  = (mag >= 1000) ? digit_char((mag / 1000) % 10) : ChSpace;
        d.c2  = digit_char((mag / 100) % 10);
        d.c4  = digit_char((mag / 10) % 10);
        d.c5  = digit_char(mag % 10);
        d.oor = 1'b0;
        if (v[31]) begin
          if (mag < 1000) d.c1 = ChMinus;
          else d.c0 = ChMinus;
        end
      end
      return d;
    endfunction

    function void note_value(input logic signed [31:0] v);
      disp_t d;
      d = format_hundredths(v);
      pending.push_back(d);
      values_seen++;
      if (v[31]) n_negative++;
      if (d.oor) n_overflow++;
    endfunction

    function void cmp_field(input string name, input logic [CharWidth-1:0] exp_v,
                            input logic [CharWidth-1:0] act_v);
      if (exp_v != act_v) begin
        $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_beat(input disp_t got);
      disp_t want;
      beats_seen++;
      if (pending.size() == 0) begin
        $error("output beat with no value outstanding: \"%c%c%c%c%c%c\"",
               got.c0, got.c1, got.c2, got.c3, got.c4, got.c5);
        errors++;
        return;
      end
      want = pending.pop_front();
      cmp_field("char_0", want.c0, got.c0);
      cmp_field("char_1", want.c1, got.c1);
      cmp_field("char_2", want.c2, got.c2);
      cmp_field("char_3", want.c3, got.c3);
      cmp_field("char_4", want.c4, got.c4);
      cmp_field("char_5", want.c5, got.c5);
      cmp_field("out_of_range", CharWidth'(want.oor), CharWidth'(got.oor));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT hookup
  // --------------------------------------------------------------------------
  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic signed [31:0]   value_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [CharWidth-1:0] char_0_o;
  logic [CharWidth-1:0] char_1_o;
  logic [CharWidth-1:0] char_2_o;
  logic [CharWidth-1:0] char_3_o;
  logic [CharWidth-1:0] char_4_o;
  logic [CharWidth-1:0] char_5_o;
  logic                 out_of_range_o;

  signed_fixed_decimal_ascii i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .char_0_o      (char_0_o),
    .char_1_o      (char_1_o),
    .char_2_o      (char_2_o),
    .char_3_o      (char_3_o),
    .char_4_o      (char_4_o),
    .char_5_o      (char_5_o),
    .out_of_range_o(out_of_range_o)
  );

  fmt_scoreboard sb;

  // 20-unit clock period
  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  int unsigned cycle_cnt;
  initial cycle_cnt = 0;
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= MaxCycles) begin
      $display("timeout after %0d cycles, %0d beats still outstanding",
               cycle_cnt, sb.pending.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: checks beats and stalls on a randomly chosen pattern, drawn anew
  // when a random countdown runs out: always ready, coin flip, mostly stalled, or toggling.
  // --------------------------------------------------------------------------
  int unsigned stall_mode;
  int unsigned stall_left;
  logic        toggle_q;

  initial begin
    stall_mode = 0;
    stall_left = 0;
    toggle_q   = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_beat({char_0_o, char_1_o, char_2_o, char_3_o,
                     char_4_o, char_5_o, out_of_range_o});
    end
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(40, 120);
    end else begin
      stall_left--;
    end
    toggle_q = ~toggle_q;
    case (stall_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= 1'($urandom_range(0, 1));
      2: out_ready_i <= ($urandom_range(0, 3) == 0);
      default: out_ready_i <= toggle_q;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sender tasks; each is entered right after a rising edge.
  // --------------------------------------------------------------------------

  // Present one value and hold it until the beat is taken.
  task automatic send_value(input logic signed [31:0] v);
    in_valid_i <= 1'b1;
    value_i    <= v;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_value(v);
  endtask

  // Drop valid for a gap set by n (none if n is 0); payload gets junk to catch sampling while idle.
  task automatic idle_gap(input int unsigned n);
    if (n != 0) begin
      in_valid_i <= 1'b0;
      value_i    <= $urandom;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Random value, weighted toward the formatting corners.
  function automatic logic signed [31:0] pick_value();
    int unsigned      sel;
    int               corners[7];
    int               v;
    corners = '{0, 99, 100, 999, 1000, 9999, 10000};
    sel = $urandom_range(0, 99);
    if (sel < 45) begin
      v = int'($urandom_range(0, 19998)) - 9999;       // anywhere in range
    end else if (sel < 65) begin
      v = int'($urandom_range(0, 1099));                // sign placement region
      if ($urandom_range(0, 1)) v = -v;
    end else if (sel < 80) begin
      v = corners[$urandom_range(0, 6)] + int'($urandom_range(0, 4)) - 2;
      if ($urandom_range(0, 1)) v = -v;
    end else begin
      v = int'($urandom);                               // full 32-bit spread
    end
    return v;
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  logic signed [31:0] directed[$];
  int unsigned        burst_left;
  int unsigned        n_sent;

  initial begin
    sb = new();
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    value_i     <= '0;
    out_ready_i <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed corners: zero, digit rollovers, sign placement on both sides
    // of 10.00, the range edges, the 32-bit extremes and alternating bits.
    directed = '{0, 1, -1, 9, -9, 10, -10, 99, -99, 100, -100, 999, -999,
                 1000, -1000, 1234, -5678, 9999, -9999, 10000, -10000,
                 32'sh7fffffff, 32'sh80000000, 32'sh55555555, 32'shaaaaaaaa};

    burst_left = $urandom_range(1, 10);
    n_sent     = 0;
    while (n_sent < directed.size() + NumRandom) begin
      if (n_sent < directed.size()) send_value(directed[n_sent]);
      else send_value(pick_value());
      n_sent++;
      burst_left--;
      if (burst_left == 0) begin
        // Back-to-back bursts now and then, otherwise a random pause.
        if ($urandom_range(0, 9) < 3) idle_gap(0);
        else idle_gap($urandom_range(1, 20));
        burst_left = $urandom_range(1, 10);
      end
    end
    in_valid_i <= 1'b0;

    // Drain, then linger long enough to catch stray beats.
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    $display("%0d values sent (%0d negative, %0d out of range), %0d beats checked",
             sb.values_seen, sb.n_negative, sb.n_overflow, sb.beats_seen);
    $display("%0d mismatches in %0d cycles", sb.errors, cycle_cnt);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/sfda_pkg.sv
rtl/core/signed_fixed_decimal_ascii.sv
test/tb_signed_fixed_decimal_ascii.sv
